FILE: rtl/mfba_pkg.sv
package mfba_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = 6;
    localparam int ADDR_W       = 2 * VERT_W;
    localparam int CAP_W        = 16;
    localparam int COUNT_W      = 7;
    localparam int RES_W        = 22;
    localparam int SUM_W        = 24;
    localparam int AUG_W        = 13;

    localparam logic [CAP_W-1:0]   CAP_LIMIT  = 16'd46340;
    localparam logic [RES_W-1:0]   RESULT_MAX = 22'h3FFFFF;
    localparam logic [COUNT_W-1:0] VC_RESET   = 7'd64;
    localparam logic [COUNT_W-1:0] VC_MAX     = 7'd64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_NEXT,
        ST_BFS_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN_RD,
        ST_SCAN_BACK,
        ST_SCAN_EVAL,
        ST_WALK_PAR,
        ST_WALK_FWD,
        ST_WALK_BACK,
        ST_WALK_EVAL,
        ST_SUM_RD,
        ST_SUM_BACK,
        ST_SUM_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [VERT_W-1:0] row;
        logic [VERT_W-1:0] col;
        logic [CAP_W-1:0]  cap;
        logic [VERT_W-1:0] src;
        logic [VERT_W-1:0] snk;
    } req_t;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] value;
        logic             is_total;
        logic             bad;
    } rsp_t;

endpackage

FILE: rtl/mfba_ram.sv
module mfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mfba_engine.sv
module mfba_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  mfba_pkg::req_t                  req,
    input  logic [mfba_pkg::COUNT_W-1:0]    n_active,
    output logic                            busy,
    output mfba_pkg::rsp_t                  rsp
);

    localparam int VW = mfba_pkg::VERT_W;
    localparam int AW = mfba_pkg::ADDR_W;
    localparam int CW = mfba_pkg::CAP_W;
    localparam int NW = mfba_pkg::COUNT_W;
    localparam int GW = mfba_pkg::AUG_W;
    localparam int SW = mfba_pkg::SUM_W;

    mfba_pkg::state_t state_reg, state_next;
    logic            clr_cap_reg, clr_cap_next;
    logic            run_reg, run_next;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [VW-1:0]   src_reg, src_next;
    logic [VW-1:0]   snk_reg, snk_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [GW-1:0]   limit_reg, limit_next;
    logic [GW-1:0]   aug_reg, aug_next;
    logic [NW-1:0]   head_reg, head_next;
    logic [NW-1:0]   tail_reg, tail_next;
    logic [VW-1:0]   u_reg, u_next;
    logic [VW-1:0]   v_reg, v_next;
    logic [VW-1:0]   cur_reg, cur_next;
    logic            vis_reg, vis_next;
    logic [CW-1:0]   capd_reg, capd_next;
    logic [CW-1:0]   flowf_reg, flowf_next;
    logic [CW-1:0]   bneck_reg, bneck_next;
    logic            phase_reg, phase_next;
    logic signed [SW-1:0] total_reg, total_next;

    logic          cap_we, flow_we, vis_we, par_we, q_we;
    logic [AW-1:0] cap_waddr, cap_raddr, flow_waddr, flow_raddr;
    logic [CW-1:0] cap_wdata, cap_rdata, flow_wdata, flow_rdata;
    logic [VW-1:0] vis_waddr, vis_raddr, par_waddr, par_raddr, q_waddr, q_raddr;
    logic          vis_wdata, vis_rdata;
    logic [VW-1:0] par_wdata, par_rdata, q_wdata, q_rdata;

    logic          v_last, fwd_pos, hit, bad_run, bad_rw;
    logic [CW-1:0] fwd_amt;
    logic [NW-1:0] tail_upd;

    mfba_ram #(.WIDTH(CW), .DEPTH(mfba_pkg::MAX_VERTICES * mfba_pkg::MAX_VERTICES)) u_cap_ram (
        .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(cap_raddr), .rdata(cap_rdata)
    );

    mfba_ram #(.WIDTH(CW), .DEPTH(mfba_pkg::MAX_VERTICES * mfba_pkg::MAX_VERTICES)) u_flow_ram (
        .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .raddr(flow_raddr), .rdata(flow_rdata)
    );

    mfba_ram #(.WIDTH(1), .DEPTH(mfba_pkg::MAX_VERTICES)) u_vis_ram (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    mfba_ram #(.WIDTH(VW), .DEPTH(mfba_pkg::MAX_VERTICES)) u_par_ram (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    mfba_ram #(.WIDTH(VW), .DEPTH(mfba_pkg::MAX_VERTICES)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mfba_pkg::ST_CLEAR;
            clr_cap_reg <= 1'b1;
            run_reg     <= 1'b0;
            clr_idx_reg <= '0;
            aug_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cap_reg <= clr_cap_next;
            run_reg     <= run_next;
            clr_idx_reg <= clr_idx_next;
            aug_reg     <= aug_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        snk_reg   <= snk_next;
        n_reg     <= n_next;
        limit_reg <= limit_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        cur_reg   <= cur_next;
        vis_reg   <= vis_next;
        capd_reg  <= capd_next;
        flowf_reg <= flowf_next;
        bneck_reg <= bneck_next;
        total_reg <= total_next;
    end

    assign v_last   = ({1'b0, v_reg} == (n_reg - NW'(1)));
    assign fwd_pos  = capd_reg > flowf_reg;
    assign fwd_amt  = capd_reg - flowf_reg;
    assign hit      = !vis_reg && (fwd_pos || (flow_rdata != '0));
    assign tail_upd = tail_reg + NW'(hit);
    assign bad_rw   = ({1'b0, req.row} >= n_active) || ({1'b0, req.col} >= n_active);
    assign bad_run  = ({1'b0, req.src} >= n_active) || ({1'b0, req.snk} >= n_active)
                      || (req.src == req.snk);
    assign busy     = (state_reg != mfba_pkg::ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_cap_next = clr_cap_reg;
        run_next     = run_reg;
        clr_idx_next = clr_idx_reg;
        src_next     = src_reg;
        snk_next     = snk_reg;
        n_next       = n_reg;
        limit_next   = limit_reg;
        aug_next     = aug_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        cur_next     = cur_reg;
        vis_next     = vis_reg;
        capd_next    = capd_reg;
        flowf_next   = flowf_reg;
        bneck_next   = bneck_reg;
        phase_next   = phase_reg;
        total_next   = total_reg;

        cap_we     = 1'b0;
        cap_waddr  = clr_idx_reg;
        cap_wdata  = '0;
        cap_raddr  = {u_reg, v_reg};
        flow_we    = 1'b0;
        flow_waddr = clr_idx_reg;
        flow_wdata = '0;
        flow_raddr = {u_reg, v_reg};
        vis_we     = 1'b0;
        vis_waddr  = v_reg;
        vis_wdata  = 1'b0;
        vis_raddr  = v_reg;
        par_we     = 1'b0;
        par_waddr  = v_reg;
        par_wdata  = u_reg;
        par_raddr  = cur_reg;
        q_we       = 1'b0;
        q_waddr    = tail_reg[VW-1:0];
        q_wdata    = v_reg;
        q_raddr    = head_reg[VW-1:0];

        rsp = '0;

        case (state_reg)
            mfba_pkg::ST_CLEAR:
            begin
                cap_we       = clr_cap_reg;
                flow_we      = 1'b1;
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == '1)
                begin
                    clr_cap_next = 1'b0;
                    aug_next     = '0;
                    state_next   = run_reg ? mfba_pkg::ST_NEXT : mfba_pkg::ST_IDLE;
                end
            end
            mfba_pkg::ST_IDLE:
            begin
                flow_raddr = {req.row, req.col};
                if (go)
                begin
                    case (req.op)
                        mfba_pkg::OP_WRITE:
                        begin
                            cap_waddr = {req.row, req.col};
                            cap_wdata = (req.cap > mfba_pkg::CAP_LIMIT) ?
                                        mfba_pkg::CAP_LIMIT : req.cap;
                            cap_we    = !bad_rw;
                        end
                        mfba_pkg::OP_RUN:
                        begin
                            if (bad_run)
                            begin
                                rsp.valid    = 1'b1;
                                rsp.is_total = 1'b1;
                                rsp.bad      = 1'b1;
                            end
                            else
                            begin
                                src_next     = req.src;
                                snk_next     = req.snk;
                                n_next       = n_active;
                                limit_next   = GW'({7'd0, n_active} * {7'd0, n_active});
                                clr_idx_next = '0;
                                run_next     = 1'b1;
                                state_next   = mfba_pkg::ST_CLEAR;
                            end
                        end
                        mfba_pkg::OP_READ:
                        begin
                            if (bad_rw)
                            begin
                                rsp.valid = 1'b1;
                                rsp.bad   = 1'b1;
                            end
                            else
                            begin
                                state_next = mfba_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = mfba_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mfba_pkg::ST_READ:
            begin
                rsp.valid  = 1'b1;
                rsp.value  = {{(mfba_pkg::RES_W - CW){1'b0}}, flow_rdata};
                state_next = mfba_pkg::ST_IDLE;
            end
            mfba_pkg::ST_NEXT:
            begin
                v_next     = '0;
                total_next = '0;
                state_next = (aug_reg < limit_reg) ? mfba_pkg::ST_BFS_INIT :
                                                     mfba_pkg::ST_SUM_RD;
            end
            mfba_pkg::ST_BFS_INIT:
            begin
                vis_we    = 1'b1;
                vis_wdata = (v_reg == src_reg);
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = src_reg;
                v_next    = v_reg + VW'(1);
                if (v_last)
                begin
                    head_next  = '0;
                    tail_next  = NW'(1);
                    state_next = mfba_pkg::ST_POP;
                end
            end
            mfba_pkg::ST_POP:
            begin
                head_next  = head_reg + NW'(1);
                state_next = mfba_pkg::ST_POP_WAIT;
            end
            mfba_pkg::ST_POP_WAIT:
            begin
                u_next     = q_rdata;
                v_next     = '0;
                state_next = mfba_pkg::ST_SCAN_RD;
            end
            mfba_pkg::ST_SCAN_RD:
            begin
                state_next = mfba_pkg::ST_SCAN_BACK;
            end
            mfba_pkg::ST_SCAN_BACK:
            begin
                vis_next   = vis_rdata;
                capd_next  = cap_rdata;
                flowf_next = flow_rdata;
                flow_raddr = {v_reg, u_reg};
                state_next = mfba_pkg::ST_SCAN_EVAL;
            end
            mfba_pkg::ST_SCAN_EVAL:
            begin
                vis_we    = hit;
                vis_wdata = 1'b1;
                par_we    = hit;
                q_we      = hit;
                tail_next = tail_upd;
                v_next    = v_reg + VW'(1);
                if (hit && (v_reg == snk_reg))
                begin
                    cur_next   = snk_reg;
                    bneck_next = mfba_pkg::CAP_LIMIT;
                    phase_next = 1'b0;
                    state_next = mfba_pkg::ST_WALK_PAR;
                end
                else if (v_last)
                begin
                    v_next     = '0;
                    total_next = '0;
                    state_next = (head_reg < tail_upd) ? mfba_pkg::ST_POP :
                                                         mfba_pkg::ST_SUM_RD;
                end
                else
                begin
                    state_next = mfba_pkg::ST_SCAN_RD;
                end
            end
            mfba_pkg::ST_WALK_PAR:
            begin
                state_next = mfba_pkg::ST_WALK_FWD;
            end
            mfba_pkg::ST_WALK_FWD:
            begin
                u_next     = par_rdata;
                cap_raddr  = {par_rdata, cur_reg};
                flow_raddr = {par_rdata, cur_reg};
                state_next = mfba_pkg::ST_WALK_BACK;
            end
            mfba_pkg::ST_WALK_BACK:
            begin
                capd_next  = cap_rdata;
                flowf_next = flow_rdata;
                flow_raddr = {cur_reg, u_reg};
                state_next = mfba_pkg::ST_WALK_EVAL;
            end
            mfba_pkg::ST_WALK_EVAL:
            begin
                if (!phase_reg)
                begin
                    if (fwd_pos)
                    begin
                        if (fwd_amt < bneck_reg)
                        begin
                            bneck_next = fwd_amt;
                        end
                    end
                    else if ((flow_rdata != '0) && (flow_rdata < bneck_reg))
                    begin
                        bneck_next = flow_rdata;
                    end
                end
                else if (fwd_pos && (bneck_reg <= fwd_amt))
                begin
                    flow_we    = 1'b1;
                    flow_waddr = {u_reg, cur_reg};
                    flow_wdata = flowf_reg + bneck_reg;
                end
                else if (!fwd_pos && (bneck_reg <= flow_rdata))
                begin
                    flow_we    = 1'b1;
                    flow_waddr = {cur_reg, u_reg};
                    flow_wdata = flow_rdata - bneck_reg;
                end
                cur_next   = u_reg;
                state_next = mfba_pkg::ST_WALK_PAR;
                if (u_reg == src_reg)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        cur_next   = snk_reg;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        aug_next   = aug_reg + GW'(1);
                        state_next = mfba_pkg::ST_NEXT;
                    end
                end
            end
            mfba_pkg::ST_SUM_RD:
            begin
                flow_raddr = {src_reg, v_reg};
                state_next = mfba_pkg::ST_SUM_BACK;
            end
            mfba_pkg::ST_SUM_BACK:
            begin
                flowf_next = flow_rdata;
                flow_raddr = {v_reg, src_reg};
                state_next = mfba_pkg::ST_SUM_ACC;
            end
            mfba_pkg::ST_SUM_ACC:
            begin
                total_next = total_reg + $signed({8'd0, flowf_reg})
                                       - $signed({8'd0, flow_rdata});
                v_next     = v_reg + VW'(1);
                state_next = v_last ? mfba_pkg::ST_DONE : mfba_pkg::ST_SUM_RD;
            end
            mfba_pkg::ST_DONE:
            begin
                rsp.valid    = 1'b1;
                rsp.is_total = 1'b1;
                if (total_reg[SW-1])
                begin
                    rsp.value = '0;
                end
                else if (total_reg[SW-2])
                begin
                    rsp.value = mfba_pkg::RESULT_MAX;
                end
                else
                begin
                    rsp.value = total_reg[mfba_pkg::RES_W-1:0];
                end
                run_next   = 1'b0;
                state_next = mfba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mfba_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= NW'(mfba_pkg::MAX_VERTICES))
        else $error("queue tail out of range");

    a_rsp_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (state_reg == mfba_pkg::ST_IDLE || state_reg == mfba_pkg::ST_READ
                       || state_reg == mfba_pkg::ST_DONE))
        else $error("result from wrong state");

    a_flow_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (flow_we && state_reg == mfba_pkg::ST_WALK_EVAL) |-> phase_reg)
        else $error("flow written during bottleneck walk");

    a_done_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mfba_pkg::ST_DONE) |-> ($past(state_reg) == mfba_pkg::ST_SUM_ACC))
        else $error("total emitted without summing");
`endif

endmodule

FILE: rtl/max_flow_bfs_augment.sv
// Channel  | Handshake              | Payload
// in       | in_valid / in_stall    | op, row_vertex, col_vertex, capacity_value,
//          |                        | source_vertex, sink_vertex
// out      | out_valid / out_stall  | result_value, is_total, bad_request
// cfg      | cfg_valid / cfg_ready  | vertex_count
//
// After reset both matrices are swept to zero with in_stall high.
// Write item: done in idle. Read item: answered after the registered flow read.
// Run item: flow clear, then per augmentation a limit check and mark clear, a pop
// and neighbour scan per dequeued vertex, and a bottleneck walk and update walk per
// path edge; then the source outflow sum and the total.
// in_stall is high while the engine is busy or a result waits on out_stall.
module max_flow_bfs_augment (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     op,
    input  logic [mfba_pkg::VERT_W-1:0]    row_vertex,
    input  logic [mfba_pkg::VERT_W-1:0]    col_vertex,
    input  logic [mfba_pkg::CAP_W-1:0]     capacity_value,
    input  logic [mfba_pkg::VERT_W-1:0]    source_vertex,
    input  logic [mfba_pkg::VERT_W-1:0]    sink_vertex,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mfba_pkg::RES_W-1:0]     result_value,
    output logic                           is_total,
    output logic                           bad_request,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mfba_pkg::COUNT_W-1:0]   vertex_count
);

    logic [mfba_pkg::COUNT_W-1:0] vc_reg, vc_next;
    logic [mfba_pkg::COUNT_W-1:0] n_active;
    logic                         out_valid_reg, out_valid_next;
    logic [mfba_pkg::RES_W-1:0]   value_reg;
    logic                         total_reg;
    logic                         bad_reg;
    logic                         busy;
    logic                         go;
    mfba_pkg::req_t               req;
    mfba_pkg::rsp_t               rsp;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy || (out_valid_reg && out_stall);
    assign go        = in_valid && !in_stall;
    assign n_active  = (vc_reg > mfba_pkg::VC_MAX) ? mfba_pkg::VC_MAX : vc_reg;

    assign req.op  = op;
    assign req.row = row_vertex;
    assign req.col = col_vertex;
    assign req.cap = capacity_value;
    assign req.src = source_vertex;
    assign req.snk = sink_vertex;

    mfba_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .req      (req),
        .n_active (n_active),
        .busy     (busy),
        .rsp      (rsp)
    );

    always_comb
    begin
        vc_next        = (cfg_valid && cfg_ready) ? vertex_count : vc_reg;
        out_valid_next = rsp.valid || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= mfba_pkg::VC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vc_reg        <= vc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.valid)
        begin
            value_reg <= rsp.value;
            total_reg <= rsp.is_total;
            bad_reg   <= rsp.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign is_total     = total_reg;
    assign bad_request  = bad_reg;

endmodule
